@@ rtl/wafc_pkg.sv @@
// ----------------------------------------------------------------------------
// wafc_pkg
// Shared widths, register map, reset values and sideband types for the
// windowed attraction force block.
// ----------------------------------------------------------------------------
package wafc_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned DIFF_W   = DATA_W + 1;        // exact difference magnitude
    localparam int unsigned SQ_W     = 2 * DIFF_W;        // sum of three squares
    localparam int unsigned ROOT_W   = SQ_W / 2;          // integer square root
    localparam int unsigned PROD_W   = 2 * DATA_W;        // dividend width
    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned S_DATA_W = 6 * DATA_W;
    localparam int unsigned M_DATA_W = ((3 * DATA_W + 1 + 7) / 8) * 8;

    // register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_LOW_BOUND  = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_HIGH_BOUND = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_FORCE_MAG  = 4'h8;

    localparam logic [DATA_W-1:0] RST_LOW_BOUND  = 32'd0;
    localparam logic [DATA_W-1:0] RST_HIGH_BOUND = 32'd655360;
    localparam logic [DATA_W-1:0] RST_FORCE_MAG  = 32'd65536;

    // geometry carried alongside the square root
    typedef struct packed {
        logic [2:0][DATA_W-1:0] ad;
        logic [2:0]             neg;
    } geo_t;

    // geometry plus window result, carried through the first divider
    typedef struct packed {
        geo_t              geo;
        logic [DATA_W-1:0] dist_len;
        logic              in_range;
        logic              zero;
    } win_t;

    // flags carried through the component dividers
    typedef struct packed {
        logic in_range;
        logic zero;
        logic neg;
    } cflag_t;

endpackage

@@ rtl/wafc_sqrt.sv @@
// ----------------------------------------------------------------------------
// wafc_sqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word travelling alongside.
// ----------------------------------------------------------------------------
module wafc_sqrt
    import wafc_pkg::*;
#(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SQ_W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [ROOT_W-1:0]    out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int unsigned REM_W = ROOT_W + 1;

    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [SQ_W-1:0]   rad_reg  [0:ROOT_W];
    logic [SIDE_W-1:0] side_reg [0:ROOT_W];
    logic              vld_reg  [0:ROOT_W];

    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign rad_reg[0]  = in_rad;
    assign side_reg[0] = in_side;
    assign vld_reg[0]  = in_valid;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             take;

        always_comb begin
            rem_sh = {rem_reg[k], rad_reg[k][SQ_W-1 -: 2]};
            trial  = {1'b0, root_reg[k], 2'b01};
            take   = rem_sh >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            if (en) begin
                rem_reg[k+1]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], take};
                rad_reg[k+1]  <= {rad_reg[k][SQ_W-3:0], 2'b00};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

@@ rtl/wafc_div.sv @@
// ----------------------------------------------------------------------------
// wafc_div
// Pipelined restoring divider, 64 by 32 bits, one quotient bit per stage.
// The quotient must fit in 32 bits; the divisor travels with the item.
// ----------------------------------------------------------------------------
module wafc_div
    import wafc_pkg::*;
#(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [PROD_W-1:0]    in_num,
    input  logic [DATA_W-1:0]    in_den,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [DATA_W-1:0]    out_quot,
    output logic [SIDE_W-1:0]    out_side
);

    logic [DATA_W-1:0] rem_reg  [0:DATA_W];
    logic [DATA_W-1:0] low_reg  [0:DATA_W];
    logic [DATA_W-1:0] quot_reg [0:DATA_W];
    logic [DATA_W-1:0] den_reg  [0:DATA_W];
    logic [SIDE_W-1:0] side_reg [0:DATA_W];
    logic              vld_reg  [0:DATA_W];

    assign rem_reg[0]  = in_num[PROD_W-1:DATA_W];
    assign low_reg[0]  = in_num[DATA_W-1:0];
    assign quot_reg[0] = '0;
    assign den_reg[0]  = in_den;
    assign side_reg[0] = in_side;
    assign vld_reg[0]  = in_valid;

    for (genvar k = 0; k < DATA_W; k++) begin : g_stage
        logic [DATA_W:0] part;
        logic            take;

        always_comb begin
            part = {rem_reg[k], low_reg[k][DATA_W-1]};
            take = part >= {1'b0, den_reg[k]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            if (en) begin
                rem_reg[k+1]  <= take ? DATA_W'(part - {1'b0, den_reg[k]})
                                      : part[DATA_W-1:0];
                low_reg[k+1]  <= {low_reg[k][DATA_W-2:0], 1'b0};
                quot_reg[k+1] <= {quot_reg[k][DATA_W-2:0], take};
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[DATA_W];
    assign out_quot  = quot_reg[DATA_W];
    assign out_side  = side_reg[DATA_W];

endmodule

@@ rtl/windowed_attraction_force.sv @@
// ----------------------------------------------------------------------------
// windowed_attraction_force
// Q16.16 attraction force between a particle and a point, windowed on
// distance, with an APB register port.
// ----------------------------------------------------------------------------
// One pair of points enters per clock and one force leaves per clock while
// the sink does not stall. The pipe has three front stages (difference,
// squares, sum), a 33-stage square root giving one bit of distance per
// stage, a window stage, the ramp multiply, a 32-stage divider for the ramp
// magnitude, the component multiplies, three parallel 32-stage dividers that
// scale by 1/distance, and the saturating output register. The whole pipe
// advances together; it holds only while a result sits in the output
// register and the sink is not ready. Registers may be written only
// while the pipe is empty.
// ----------------------------------------------------------------------------
module windowed_attraction_force
    import wafc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // self_x, self_y, self_z, other_x, other_y, other_z
    input  logic [S_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // force_x, force_y, force_z, in_range, zero padding
    output logic [M_DATA_W-1:0]    m_tdata
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] low_bound_reg;
    logic [DATA_W-1:0] high_bound_reg;
    logic [DATA_W-1:0] force_mag_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_bound_reg  <= RST_LOW_BOUND;
            high_bound_reg <= RST_HIGH_BOUND;
            force_mag_reg  <= RST_FORCE_MAG;
        end else if (cfg_wr) begin
            unique case (paddr)
                ADDR_LOW_BOUND:  low_bound_reg  <= pwdata;
                ADDR_HIGH_BOUND: high_bound_reg <= pwdata;
                ADDR_FORCE_MAG:  force_mag_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_LOW_BOUND:  prdata = low_bound_reg;
            ADDR_HIGH_BOUND: prdata = high_bound_reg;
            ADDR_FORCE_MAG:  prdata = force_mag_reg;
            default:         prdata = '0;
        endcase
    end

    // The user must keep bounds and magnitude static while items are in flight;
    // the block does not enforce this. Every stage reads them directly.
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] abs_mag;
    logic              mag_neg;

    assign span    = high_bound_reg - low_bound_reg;
    assign mag_neg = force_mag_reg[DATA_W-1];
    assign abs_mag = mag_neg ? DATA_W'(-force_mag_reg) : force_mag_reg;

    // ------------------------------------------------------------------
    // Pipe advance: hold everything while the output transfer is stalled
    // ------------------------------------------------------------------
    logic m_valid_reg;
    logic en;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: exact differences and their magnitudes
    // ------------------------------------------------------------------
    logic [2:0][DIFF_W-1:0] ad_next;
    logic [2:0]             neg_next;
    logic [2:0][DIFF_W-1:0] ad_reg;
    logic [2:0]             neg_reg;
    logic                   v1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [DIFF_W-1:0] d;
            d = DIFF_W'($signed(s_tdata[(i+3)*DATA_W +: DATA_W]))
              - DIFF_W'($signed(s_tdata[i*DATA_W +: DATA_W]));
            neg_next[i] = d[DIFF_W-1];
            ad_next[i]  = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares; stage 3: sum of squares
    // ------------------------------------------------------------------
    logic [2:0][SQ_W-1:0] sq_reg;
    logic [2:0]           neg2_reg;
    logic [2:0][DATA_W-1:0] ad2_reg;
    logic                 v2_reg;
    logic [SQ_W-1:0]      sum_reg;
    geo_t                 geo3_reg;
    logic                 v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            ad_reg   <= ad_next;
            neg_reg  <= neg_next;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i]  <= SQ_W'(ad_reg[i] * ad_reg[i]);
                // beyond 32 bits the distance is out of any window
                ad2_reg[i] <= ad_reg[i][DATA_W-1:0];
            end
            neg2_reg     <= neg_reg;
            sum_reg      <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            geo3_reg.ad  <= ad2_reg;
            geo3_reg.neg <= neg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: distance
    // ------------------------------------------------------------------
    logic              sq_valid;
    logic [ROOT_W-1:0] dist_root;
    logic [$bits(geo_t)-1:0] sq_side;

    wafc_sqrt #(.SIDE_W($bits(geo_t))) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (sum_reg),
        .in_side   (geo3_reg),
        .out_valid (sq_valid),
        .out_root  (dist_root),
        .out_side  (sq_side)
    );

    // ------------------------------------------------------------------
    // Window test, then ramp numerator |force_magnitude| * (dist - low)
    // ------------------------------------------------------------------
    win_t              win_reg;
    logic [DATA_W-1:0] rise_reg;
    logic              v4_reg;
    win_t              win5_reg;
    logic [PROD_W-1:0] ramp_reg;
    logic              v5_reg;
    logic              in_win;

    assign in_win = (dist_root >= ROOT_W'(low_bound_reg))
                 && (dist_root <= ROOT_W'(high_bound_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq_valid;
            v5_reg <= v4_reg;
        end
        if (en) begin
            win_reg.geo      <= geo_t'(sq_side);
            win_reg.dist_len <= dist_root[DATA_W-1:0];
            win_reg.in_range <= in_win;
            // drop the force outside the window, at zero length or zero span
            win_reg.zero     <= !in_win || (dist_root == '0) || (span == '0);
            rise_reg         <= dist_root[DATA_W-1:0] - low_bound_reg;
            win5_reg         <= win_reg;
            ramp_reg         <= PROD_W'(abs_mag * rise_reg);
        end
    end

    // ------------------------------------------------------------------
    // Ramp magnitude: ramp numerator / span
    // ------------------------------------------------------------------
    logic                   d1_valid;
    logic [DATA_W-1:0]      mag;
    logic [$bits(win_t)-1:0] d1_side;
    win_t                   d1_win;

    wafc_div #(.SIDE_W($bits(win_t))) u_div_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num    (ramp_reg),
        .in_den    (span),
        .in_side   (win5_reg),
        .out_valid (d1_valid),
        .out_quot  (mag),
        .out_side  (d1_side)
    );

    assign d1_win = win_t'(d1_side);

    // ------------------------------------------------------------------
    // Component numerators |d| * mag
    // ------------------------------------------------------------------
    logic [2:0][PROD_W-1:0] cnum_reg;
    logic [DATA_W-1:0]      dist6_reg;
    cflag_t [2:0]           cflag_reg;
    logic                   v6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= d1_valid;
        end
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                cnum_reg[i]           <= PROD_W'(d1_win.geo.ad[i] * mag);
                cflag_reg[i].in_range <= d1_win.in_range;
                cflag_reg[i].zero     <= d1_win.zero;
                cflag_reg[i].neg      <= d1_win.geo.neg[i] ^ mag_neg;
            end
            dist6_reg <= d1_win.dist_len;
        end
    end

    // ------------------------------------------------------------------
    // Unit vector scaling: three dividers by the distance
    // ------------------------------------------------------------------
    logic [2:0]              d2_valid;
    logic [2:0][DATA_W-1:0]  cmag;
    logic [2:0][$bits(cflag_t)-1:0] d2_side;

    for (genvar i = 0; i < 3; i++) begin : g_comp
        wafc_div #(.SIDE_W($bits(cflag_t))) u_div_comp (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v6_reg),
            .in_num    (cnum_reg[i]),
            .in_den    (dist6_reg),
            .in_side   (cflag_reg[i]),
            .out_valid (d2_valid[i]),
            .out_quot  (cmag[i]),
            .out_side  (d2_side[i])
        );
    end

    // ------------------------------------------------------------------
    // Sign, saturation and output register
    // ------------------------------------------------------------------
    logic [2:0][DATA_W-1:0] force_next;
    logic [M_DATA_W-1:0]    m_data_reg;
    cflag_t [2:0]           cf;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cf[i] = cflag_t'(d2_side[i]);
            if (cf[i].zero) begin
                force_next[i] = '0;
            end else if (cf[i].neg) begin
                force_next[i] = DATA_W'(-cmag[i]);
            end else if (cmag[i][DATA_W-1]) begin
                force_next[i] = {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
                force_next[i] = cmag[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= d2_valid[0];
        end
        if (en) begin
            m_data_reg <= M_DATA_W'({cf[0].in_range, force_next[2], force_next[1],
                                     force_next[0]});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while output stalled");

    a_out_of_window_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3*DATA_W] |-> m_tdata[3*DATA_W-1:0] == '0)
        else $error("non-zero force outside the window");

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        d2_valid[0] == d2_valid[1] && d2_valid[1] == d2_valid[2])
        else $error("component dividers out of step");

    a_reset_empty: assert property (@(posedge aclk)
        aresetn && !$past(aresetn) |-> !m_tvalid)
        else $error("result valid straight after reset");

endmodule
